// ===== src/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types, character codes and word tables of the token scanner.
// ----------------------------------------------------------------------------
package cst_pkg;

    typedef enum logic [3:0] {
        KIND_INT    = 4'd0,
        KIND_PUNCT  = 4'd1,
        KIND_SOP    = 4'd2,
        KIND_BOP    = 4'd3,
        KIND_ASSIGN = 4'd4,
        KIND_STR    = 4'd5,
        KIND_TYPE   = 4'd6,
        KIND_KEY    = 4'd7,
        KIND_IDENT  = 4'd8,
        KIND_END    = 4'd9,
        KIND_ERR    = 4'd10
    } kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_INT  = 3'd1,
        MODE_DOP  = 3'd2,
        MODE_STR  = 3'd3,
        MODE_WORD = 3'd4,
        MODE_HALT = 3'd5
    } mode_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] start_pos;
        logic [7:0]  length;
        logic [7:0]  first_char;
        logic [7:0]  second_char;
        logic        last;
    } result_t;

    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = 2;
    localparam int RQ_CW    = 3;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_BAR     = 8'h7C;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_BANG    = 8'h21;

    // bool, int, void, while; padded with zeros
    localparam logic [7:0] WORD_TEXT [4][8] = '{
        '{8'h62, 8'h6F, 8'h6F, 8'h6C, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h76, 8'h6F, 8'h69, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [7:0] WORD_LEN [4] = '{8'd4, 8'd3, 8'd4, 8'd5};

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACE) ||
               (c == CH_RBRACE) || (c == CH_SEMI);
    endfunction

    function automatic logic is_sop(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_SLASH) ||
               (c == CH_STAR) || (c == CH_PERCENT);
    endfunction

    function automatic logic is_dop(input logic [7:0] c);
        return (c == CH_EQ) || (c == CH_BAR) || (c == CH_AMP) ||
               (c == CH_LT) || (c == CH_GT) || (c == CH_BANG);
    endfunction

    function automatic kind_t word_kind(input logic [3:0] flags, input logic [7:0] len);
        kind_t k;
        k = KIND_IDENT;
        if (flags[0] && (len == WORD_LEN[0])) k = KIND_TYPE;
        else if (flags[1] && (len == WORD_LEN[1])) k = KIND_TYPE;
        else if (flags[2] && (len == WORD_LEN[2])) k = KIND_TYPE;
        else if (flags[3] && (len == WORD_LEN[3])) k = KIND_KEY;
        return k;
    endfunction

    function automatic result_t make_res(input kind_t k, input logic [31:0] start,
                                         input logic [7:0] len, input logic [15:0] held);
        result_t r;
        r.kind        = k;
        r.start_pos   = start;
        r.length      = len;
        r.first_char  = held[7:0];
        r.second_char = held[15:8];
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

// ===== src/cst_if.sv =====
// ----------------------------------------------------------------------------
// cst_if
// Valid/ready channels of the token scanner: characters in, tokens out.
// ----------------------------------------------------------------------------
interface cst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_input;

    modport source (output valid, output ch, output end_of_input, input ready);
    modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface cst_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [31:0] start_pos;
    logic [7:0]  length;
    logic [7:0]  first_char;
    logic [7:0]  second_char;
    logic        last;

    modport source (output valid, output kind, output start_pos, output length,
                    output first_char, output second_char, output last, input ready);
    modport sink   (input valid, input kind, input start_pos, input length,
                    input first_char, input second_char, input last, output ready);
endinterface

// ===== src/cst_scan_core.sv =====
// ----------------------------------------------------------------------------
// cst_scan_core
// Scanner state and combinational classification of one request; yields up to
// two tokens per request.
// ----------------------------------------------------------------------------
module cst_scan_core #(
    parameter int MAX_TOKEN = 128
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       ch,
    input  logic             end_of_input,
    output logic             res0_valid,
    output cst_pkg::result_t res0,
    output logic             res1_valid,
    output cst_pkg::result_t res1
);

    localparam logic [7:0] MaxLen = 8'(MAX_TOKEN);

    cst_pkg::mode_t mode_reg, mode_next;
    logic [31:0]    pos_reg, pos_next;
    logic [31:0]    start_reg, start_next;
    logic [7:0]     len_reg, len_next;
    logic [15:0]    held_reg, held_next;
    logic [3:0]     flags_reg, flags_next;

    // fresh-token scan of ch at the current position
    cst_pkg::mode_t   id_mode;
    logic             id_set;
    logic [31:0]      id_start;
    logic [7:0]       id_len;
    logic [15:0]      id_held;
    logic [3:0]       id_flags;
    logic             id_v;
    cst_pkg::result_t id_res;

    logic        full;
    logic [15:0] held_ext;
    logic [3:0]  flags_ext;
    logic [31:0] pos_inc;

    logic             a_v;
    cst_pkg::result_t a_res;
    logic             b_v;
    cst_pkg::result_t b_res;

    assign full     = (len_reg >= MaxLen);
    assign pos_inc  = pos_reg + 32'd1;
    assign held_ext = (len_reg == 8'd0) ? {8'h00, ch} :
                      (len_reg == 8'd1) ? {ch, held_reg[7:0]} : held_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            flags_ext[k] = flags_reg[k] && (len_reg < cst_pkg::WORD_LEN[k]) &&
                           (cst_pkg::WORD_TEXT[k][len_reg[2:0]] == ch);
        end
    end

    always_comb
    begin
        id_mode  = cst_pkg::MODE_IDLE;
        id_set   = 1'b0;
        id_start = pos_reg;
        id_len   = 8'd1;
        id_held  = {8'h00, ch};
        id_flags = flags_reg;
        id_v     = 1'b0;
        id_res   = cst_pkg::make_res(cst_pkg::KIND_ERR, pos_reg, 8'd0, {8'h00, ch});
        if (cst_pkg::is_digit(ch))
        begin
            id_mode = cst_pkg::MODE_INT;
            id_set  = 1'b1;
        end
        else if (cst_pkg::is_punct(ch))
        begin
            id_v   = 1'b1;
            id_res = cst_pkg::make_res(cst_pkg::KIND_PUNCT, pos_reg, 8'd1, {8'h00, ch});
        end
        else if (cst_pkg::is_sop(ch))
        begin
            id_v   = 1'b1;
            id_res = cst_pkg::make_res(cst_pkg::KIND_SOP, pos_reg, 8'd1, {8'h00, ch});
        end
        else if (cst_pkg::is_dop(ch))
        begin
            id_mode = cst_pkg::MODE_DOP;
            id_set  = 1'b1;
        end
        else if (ch == cst_pkg::CH_QUOTE)
        begin
            id_mode  = cst_pkg::MODE_STR;
            id_set   = 1'b1;
            id_start = pos_inc;
            id_len   = 8'd0;
            id_held  = 16'h0000;
        end
        else if (cst_pkg::is_letter(ch))
        begin
            id_mode = cst_pkg::MODE_WORD;
            id_set  = 1'b1;
            for (int k = 0; k < 4; k++)
            begin
                id_flags[k] = (cst_pkg::WORD_TEXT[k][0] == ch);
            end
        end
        else if ((ch == cst_pkg::CH_SPACE) || (ch == cst_pkg::CH_NL))
        begin
            id_mode = cst_pkg::MODE_IDLE;
        end
        else
        begin
            id_mode = cst_pkg::MODE_HALT;
            id_v    = 1'b1;
        end
    end

    // next state
    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        len_next   = len_reg;
        held_next  = held_reg;
        flags_next = flags_reg;
        if (accept && (mode_reg != cst_pkg::MODE_HALT))
        begin
            if (end_of_input)
            begin
                if (mode_reg == cst_pkg::MODE_STR)
                begin
                    mode_next = cst_pkg::MODE_HALT;
                end
                else
                begin
                    mode_next  = cst_pkg::MODE_IDLE;
                    pos_next   = 32'd0;
                    start_next = 32'd0;
                    len_next   = 8'd0;
                    held_next  = 16'h0000;
                    flags_next = 4'h0;
                end
            end
            else
            begin
                pos_next = pos_inc;
                unique case (mode_reg)
                    cst_pkg::MODE_INT:
                    begin
                        if (cst_pkg::is_digit(ch))
                        begin
                            if (full)
                            begin
                                mode_next = cst_pkg::MODE_HALT;
                            end
                            else
                            begin
                                len_next  = len_reg + 8'd1;
                                held_next = held_ext;
                            end
                        end
                        else
                        begin
                            mode_next  = id_mode;
                            flags_next = id_flags;
                            if (id_set)
                            begin
                                start_next = id_start;
                                len_next   = id_len;
                                held_next  = id_held;
                            end
                        end
                    end
                    cst_pkg::MODE_DOP:
                    begin
                        if (cst_pkg::is_dop(ch))
                        begin
                            mode_next = cst_pkg::MODE_IDLE;
                            held_next = {ch, held_reg[7:0]};
                        end
                        else
                        begin
                            mode_next  = id_mode;
                            flags_next = id_flags;
                            if (id_set)
                            begin
                                start_next = id_start;
                                len_next   = id_len;
                                held_next  = id_held;
                            end
                        end
                    end
                    cst_pkg::MODE_STR:
                    begin
                        if (ch == cst_pkg::CH_QUOTE)
                        begin
                            mode_next = cst_pkg::MODE_IDLE;
                        end
                        else if (full)
                        begin
                            mode_next = cst_pkg::MODE_HALT;
                        end
                        else
                        begin
                            len_next  = len_reg + 8'd1;
                            held_next = held_ext;
                        end
                    end
                    cst_pkg::MODE_WORD:
                    begin
                        if (cst_pkg::is_letter(ch))
                        begin
                            if (full)
                            begin
                                mode_next = cst_pkg::MODE_HALT;
                            end
                            else
                            begin
                                len_next   = len_reg + 8'd1;
                                held_next  = held_ext;
                                flags_next = flags_ext;
                            end
                        end
                        else
                        begin
                            mode_next  = id_mode;
                            flags_next = id_flags;
                            if (id_set)
                            begin
                                start_next = id_start;
                                len_next   = id_len;
                                held_next  = id_held;
                            end
                        end
                    end
                    default:
                    begin
                        mode_next  = id_mode;
                        flags_next = id_flags;
                        if (id_set)
                        begin
                            start_next = id_start;
                            len_next   = id_len;
                            held_next  = id_held;
                        end
                    end
                endcase
            end
        end
    end

    // results: a closes the pending token or reports its error, b comes from the fresh scan or end
    always_comb
    begin
        a_v   = 1'b0;
        a_res = cst_pkg::make_res(cst_pkg::KIND_INT, start_reg, len_reg, held_reg);
        b_v   = 1'b0;
        b_res = id_res;
        if (accept && (mode_reg != cst_pkg::MODE_HALT))
        begin
            if (end_of_input)
            begin
                b_v   = (mode_reg != cst_pkg::MODE_STR);
                b_res = cst_pkg::make_res(cst_pkg::KIND_END, pos_reg, 8'd0, 16'h0000);
                unique case (mode_reg)
                    cst_pkg::MODE_INT:
                    begin
                        a_v = 1'b1;
                    end
                    cst_pkg::MODE_DOP:
                    begin
                        a_v   = 1'b1;
                        a_res = cst_pkg::make_res((held_reg[7:0] == cst_pkg::CH_EQ) ?
                                    cst_pkg::KIND_ASSIGN : cst_pkg::KIND_BOP,
                                    start_reg, 8'd1, held_reg);
                    end
                    cst_pkg::MODE_WORD:
                    begin
                        a_v   = 1'b1;
                        a_res = cst_pkg::make_res(cst_pkg::word_kind(flags_reg, len_reg),
                                    start_reg, len_reg, held_reg);
                    end
                    cst_pkg::MODE_STR:
                    begin
                        a_v   = 1'b1;
                        a_res = cst_pkg::make_res(cst_pkg::KIND_ERR, pos_reg, 8'd0, 16'h0000);
                    end
                    default:
                    begin
                        a_v = 1'b0;
                    end
                endcase
            end
            else
            begin
                unique case (mode_reg)
                    cst_pkg::MODE_INT:
                    begin
                        if (cst_pkg::is_digit(ch))
                        begin
                            a_v   = full;
                            a_res = cst_pkg::make_res(cst_pkg::KIND_ERR, pos_reg, 8'd0,
                                                      {8'h00, ch});
                        end
                        else
                        begin
                            a_v = 1'b1;
                            b_v = id_v;
                        end
                    end
                    cst_pkg::MODE_DOP:
                    begin
                        a_v = 1'b1;
                        if (cst_pkg::is_dop(ch))
                        begin
                            a_res = cst_pkg::make_res(cst_pkg::KIND_BOP, start_reg, 8'd2,
                                                      {ch, held_reg[7:0]});
                        end
                        else
                        begin
                            a_res = cst_pkg::make_res((held_reg[7:0] == cst_pkg::CH_EQ) ?
                                        cst_pkg::KIND_ASSIGN : cst_pkg::KIND_BOP,
                                        start_reg, 8'd1, held_reg);
                            b_v   = id_v;
                        end
                    end
                    cst_pkg::MODE_STR:
                    begin
                        if (ch == cst_pkg::CH_QUOTE)
                        begin
                            a_v   = 1'b1;
                            a_res = cst_pkg::make_res(cst_pkg::KIND_STR, start_reg, len_reg,
                                                      held_reg);
                        end
                        else
                        begin
                            a_v   = full;
                            a_res = cst_pkg::make_res(cst_pkg::KIND_ERR, pos_reg, 8'd0,
                                                      {8'h00, ch});
                        end
                    end
                    cst_pkg::MODE_WORD:
                    begin
                        if (cst_pkg::is_letter(ch))
                        begin
                            a_v   = full;
                            a_res = cst_pkg::make_res(cst_pkg::KIND_ERR, pos_reg, 8'd0,
                                                      {8'h00, ch});
                        end
                        else
                        begin
                            a_v   = 1'b1;
                            a_res = cst_pkg::make_res(cst_pkg::word_kind(flags_reg, len_reg),
                                        start_reg, len_reg, held_reg);
                            b_v   = id_v;
                        end
                    end
                    default:
                    begin
                        b_v = id_v;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        res0_valid = a_v || b_v;
        res0       = a_v ? a_res : b_res;
        res0.last  = !(a_v && b_v);
        res1_valid = a_v && b_v;
        res1       = b_res;
        res1.last  = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= cst_pkg::MODE_IDLE;
            pos_reg   <= 32'd0;
            start_reg <= 32'd0;
            len_reg   <= 8'd0;
            held_reg  <= 16'h0000;
            flags_reg <= 4'h0;
        end
        else
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            held_reg  <= held_next;
            flags_reg <= flags_next;
        end
    end

endmodule

// ===== src/cst_result_queue.sv =====
// ----------------------------------------------------------------------------
// cst_result_queue
// Small token queue: takes up to two tokens a cycle, hands out one.
// ----------------------------------------------------------------------------
module cst_result_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push0,
    input  cst_pkg::result_t data0,
    input  logic             push1,
    input  cst_pkg::result_t data1,
    output logic             room,
    output logic             head_valid,
    output cst_pkg::result_t head,
    input  logic             pop
);

    cst_pkg::result_t              q_reg [cst_pkg::RQ_DEPTH];
    logic [cst_pkg::RQ_AW-1:0]     rd_reg, rd_next;
    logic [cst_pkg::RQ_AW-1:0]     wr_reg, wr_next;
    logic [cst_pkg::RQ_AW-1:0]     wr_alt;
    logic [cst_pkg::RQ_CW-1:0]     cnt_reg, cnt_next;
    logic                          do_pop;

    assign head_valid = (cnt_reg != '0);
    assign head       = q_reg[rd_reg];
    assign room       = (cnt_reg <= cst_pkg::RQ_CW'(cst_pkg::RQ_DEPTH - 2));
    assign do_pop     = pop && head_valid;
    assign wr_alt     = wr_reg + cst_pkg::RQ_AW'(1);

    always_comb
    begin
        rd_next  = do_pop ? rd_reg + cst_pkg::RQ_AW'(1) : rd_reg;
        wr_next  = wr_reg + cst_pkg::RQ_AW'(push0) + cst_pkg::RQ_AW'(push1);
        cnt_next = cnt_reg + cst_pkg::RQ_CW'(push0) + cst_pkg::RQ_CW'(push1)
                   - cst_pkg::RQ_CW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < cst_pkg::RQ_DEPTH; i++)
        begin
            if (push0 && (wr_reg == cst_pkg::RQ_AW'(i)))
            begin
                q_reg[i] <= data0;
            end
            else if (push1 && (wr_alt == cst_pkg::RQ_AW'(i)))
            begin
                q_reg[i] <= data1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== src/c_subset_token_scanner.sv =====
// A token is written into a four-entry token queue when the request that closes it is
// accepted, and is offered on the output from the queue head. Throughput: one character
// request per cycle while the queue has room; it absorbs requests that yield two tokens.
// Input stalls while fewer than two queue entries are free.
// Reset (rst_n low, asynchronous) clears the scanner to idle at offset zero and
// empties the queue; an error halts the scanner until the next reset.
// ----------------------------------------------------------------------------
// c_subset_token_scanner
// Byte-per-cycle lexer, while the token queue has room, for a small C subset,
// reporting tokens by kind, position, length and leading characters.
// ----------------------------------------------------------------------------
module c_subset_token_scanner #(
    parameter int MAX_TOKEN = 128
) (
    input  logic      clk,
    input  logic      rst_n,
    cst_in_if.sink    chars,
    cst_out_if.source tokens
);

    logic             accept;
    logic             room;
    logic             res0_valid;
    logic             res1_valid;
    cst_pkg::result_t res0;
    cst_pkg::result_t res1;
    logic             head_valid;
    cst_pkg::result_t head;

    assign chars.ready = room;
    assign accept      = chars.valid && room;

    cst_scan_core #(
        .MAX_TOKEN (MAX_TOKEN)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .ch           (chars.ch),
        .end_of_input (chars.end_of_input),
        .res0_valid   (res0_valid),
        .res0         (res0),
        .res1_valid   (res1_valid),
        .res1         (res1)
    );

    cst_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push0      (res0_valid),
        .data0      (res0),
        .push1      (res1_valid),
        .data1      (res1),
        .room       (room),
        .head_valid (head_valid),
        .head       (head),
        .pop        (tokens.ready)
    );

    assign tokens.valid       = head_valid;
    assign tokens.kind        = head.kind;
    assign tokens.start_pos   = head.start_pos;
    assign tokens.length      = head.length;
    assign tokens.first_char  = head.first_char;
    assign tokens.second_char = head.second_char;
    assign tokens.last        = head.last;

endmodule

// ===== src/cst_checker.sv =====
// ----------------------------------------------------------------------------
// cst_checker
// Port-level checks of the token scanner, bound to the top level.
// ----------------------------------------------------------------------------
module cst_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        tok_valid,
    input logic        tok_ready,
    input logic [3:0]  tok_kind,
    input logic [31:0] tok_start_pos,
    input logic [7:0]  tok_length,
    input logic [7:0]  tok_first_char,
    input logic        tok_last
);

    // hold a stalled token
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_ready |=> tok_valid && $stable(tok_kind) &&
        $stable(tok_start_pos))
    else $error("stalled token changed");

    // the output goes idle after an error token is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_ready && (tok_kind == cst_pkg::KIND_ERR) |=> !tok_valid)
    else $error("token after error");

    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && (tok_kind == cst_pkg::KIND_END) |->
        (tok_length == 8'd0) && (tok_first_char == 8'h00) && tok_last)
    else $error("malformed end token");

    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && ((tok_kind == cst_pkg::KIND_PUNCT) || (tok_kind == cst_pkg::KIND_SOP) ||
        (tok_kind == cst_pkg::KIND_ASSIGN)) |-> (tok_length == 8'd1))
    else $error("single-character token with wrong length");

    assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && (tok_kind == cst_pkg::KIND_ERR) |-> tok_last && (tok_length == 8'd0))
    else $error("malformed error token");

endmodule

bind c_subset_token_scanner cst_checker u_cst_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .tok_valid      (tokens.valid),
    .tok_ready      (tokens.ready),
    .tok_kind       (tokens.kind),
    .tok_start_pos  (tokens.start_pos),
    .tok_length     (tokens.length),
    .tok_first_char (tokens.first_char),
    .tok_last       (tokens.last)
);

// ===== verif/c_subset_token_scanner_tb.sv =====
// ----------------------------------------------------------------------------
// c_subset_token_scanner_tb
// Drives character requests into the scanner, with random gaps on the input
// and random stalls on the token output. A scoreboard class keeps its own
// lexer state, predicts the tokens of every accepted request and checks each
// token as it leaves the block. A run ends with a single fault case: an
// unknown byte, an over-long token or an unterminated string.
// ----------------------------------------------------------------------------
module c_subset_token_scanner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOKEN_LIMIT    = 128;
    localparam int RANDOM_ITEMS   = 1320;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;

    typedef enum {TK_INT, TK_WORD, TK_PUNCT, TK_SOP, TK_DOP, TK_STR} token_class_t;
    typedef enum {FLT_BAD_CHAR, FLT_TOO_LONG, FLT_OPEN_STRING} fault_t;

    localparam logic [7:0] PUNCT_SET [5] = '{cst_pkg::CH_LPAREN, cst_pkg::CH_RPAREN,
                                             cst_pkg::CH_LBRACE, cst_pkg::CH_RBRACE,
                                             cst_pkg::CH_SEMI};
    localparam logic [7:0] SOP_SET [5]   = '{cst_pkg::CH_PLUS, cst_pkg::CH_MINUS,
                                             cst_pkg::CH_SLASH, cst_pkg::CH_STAR,
                                             cst_pkg::CH_PERCENT};
    localparam logic [7:0] DOP_SET [6]   = '{cst_pkg::CH_EQ, cst_pkg::CH_BAR, cst_pkg::CH_AMP,
                                             cst_pkg::CH_LT, cst_pkg::CH_GT, cst_pkg::CH_BANG};

    class token_scoreboard;
        cst_pkg::mode_t   mode;
        logic [31:0]      offset;
        logic [31:0]      tok_start;
        logic [7:0]       tok_len;
        logic [15:0]      lead;
        logic [3:0]       word_hits;
        cst_pkg::result_t token_q[$];
        cst_pkg::result_t fresh[$];
        int               errors;

        function new();
            errors = 0;
            restart();
        endfunction

        static function string reserved_word(int k);
            case (k)
                0: return "bool";
                1: return "int";
                2: return "void";
                default: return "while";
            endcase
        endfunction

        static function bit is_digit(logic [7:0] c);
            return c >= 8'h30 && c <= 8'h39;
        endfunction

        static function bit is_letter(logic [7:0] c);
            return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
        endfunction

        static function bit is_punct(logic [7:0] c);
            return c == cst_pkg::CH_LPAREN || c == cst_pkg::CH_RPAREN ||
                   c == cst_pkg::CH_LBRACE || c == cst_pkg::CH_RBRACE ||
                   c == cst_pkg::CH_SEMI;
        endfunction

        static function bit is_sop(logic [7:0] c);
            return c == cst_pkg::CH_PLUS || c == cst_pkg::CH_MINUS ||
                   c == cst_pkg::CH_SLASH || c == cst_pkg::CH_STAR ||
                   c == cst_pkg::CH_PERCENT;
        endfunction

        static function bit is_dop(logic [7:0] c);
            return c == cst_pkg::CH_EQ || c == cst_pkg::CH_BAR || c == cst_pkg::CH_AMP ||
                   c == cst_pkg::CH_LT || c == cst_pkg::CH_GT || c == cst_pkg::CH_BANG;
        endfunction

        static function bit is_known(logic [7:0] c);
            return is_digit(c) || is_letter(c) || is_punct(c) || is_sop(c) || is_dop(c) ||
                   c == cst_pkg::CH_QUOTE || c == cst_pkg::CH_SPACE || c == cst_pkg::CH_NL;
        endfunction

        function void restart();
            mode      = cst_pkg::MODE_IDLE;
            offset    = '0;
            tok_start = '0;
            tok_len   = '0;
            lead      = '0;
            word_hits = '0;
        endfunction

        function int pending();
            return token_q.size();
        endfunction

        function void add(cst_pkg::kind_t k, logic [31:0] start, logic [7:0] len,
                          logic [15:0] held);
            cst_pkg::result_t r;
            r.kind        = k;
            r.start_pos   = start;
            r.length      = len;
            r.first_char  = held[7:0];
            r.second_char = held[15:8];
            r.last        = 1'b0;
            fresh.push_back(r);
        endfunction

        function void halt(logic [31:0] at, logic [7:0] c);
            add(cst_pkg::KIND_ERR, at, 8'd0, {8'h00, c});
            mode = cst_pkg::MODE_HALT;
        endfunction

        function void open(cst_pkg::mode_t m, logic [7:0] c, logic [31:0] at);
            mode      = m;
            tok_start = at;
            tok_len   = 8'd1;
            lead      = {8'h00, c};
        endfunction

        function bit grow(logic [7:0] c);
            if (int'(tok_len) >= TOKEN_LIMIT)
                return 1'b0;
            if (tok_len == 8'd0)
                lead = {8'h00, c};
            else if (tok_len == 8'd1)
                lead[15:8] = c;
            tok_len++;
            return 1'b1;
        endfunction

        function cst_pkg::kind_t op_kind();
            return (lead[7:0] == cst_pkg::CH_EQ) ? cst_pkg::KIND_ASSIGN : cst_pkg::KIND_BOP;
        endfunction

        function void close_word();
            cst_pkg::kind_t k;
            k = cst_pkg::KIND_IDENT;
            for (int i = 3; i >= 0; i--)
            begin
                if (word_hits[i] && int'(tok_len) == reserved_word(i).len())
                    k = (i < 3) ? cst_pkg::KIND_TYPE : cst_pkg::KIND_KEY;
            end
            add(k, tok_start, tok_len, lead);
        endfunction

        function void scan_fresh(logic [7:0] c, logic [31:0] at);
            string w;
            mode = cst_pkg::MODE_IDLE;
            if (is_digit(c))
                open(cst_pkg::MODE_INT, c, at);
            else if (is_punct(c))
                add(cst_pkg::KIND_PUNCT, at, 8'd1, {8'h00, c});
            else if (is_sop(c))
                add(cst_pkg::KIND_SOP, at, 8'd1, {8'h00, c});
            else if (is_dop(c))
                open(cst_pkg::MODE_DOP, c, at);
            else if (c == cst_pkg::CH_QUOTE)
            begin
                mode      = cst_pkg::MODE_STR;
                tok_start = at + 32'd1;
                tok_len   = 8'd0;
                lead      = '0;
            end
            else if (is_letter(c))
            begin
                open(cst_pkg::MODE_WORD, c, at);
                word_hits = '0;
                for (int i = 0; i < 4; i++)
                begin
                    w = reserved_word(i);
                    if (w[0] == c)
                        word_hits[i] = 1'b1;
                end
            end
            else if (c != cst_pkg::CH_SPACE && c != cst_pkg::CH_NL)
                halt(at, c);
        endfunction

        function void note_char(logic [7:0] c, logic eoi);
            logic [31:0] at;
            int          idx;
            string       w;
            fresh.delete();
            if (mode == cst_pkg::MODE_HALT)
                return;
            if (eoi)
            begin
                case (mode)
                    cst_pkg::MODE_INT:  add(cst_pkg::KIND_INT, tok_start, tok_len, lead);
                    cst_pkg::MODE_DOP:  add(op_kind(), tok_start, 8'd1, lead);
                    cst_pkg::MODE_WORD: close_word();
                    cst_pkg::MODE_STR:  halt(offset, 8'h00);
                    default: ;
                endcase
                if (mode != cst_pkg::MODE_HALT)
                begin
                    add(cst_pkg::KIND_END, offset, 8'd0, 16'h0000);
                    restart();
                end
            end
            else
            begin
                at     = offset;
                offset = at + 32'd1;
                case (mode)
                    cst_pkg::MODE_INT:
                        if (is_digit(c))
                        begin
                            if (!grow(c))
                                halt(at, c);
                        end
                        else
                        begin
                            add(cst_pkg::KIND_INT, tok_start, tok_len, lead);
                            scan_fresh(c, at);
                        end
                    cst_pkg::MODE_DOP:
                        if (is_dop(c))
                        begin
                            lead[15:8] = c;
                            add(cst_pkg::KIND_BOP, tok_start, 8'd2, lead);
                            mode = cst_pkg::MODE_IDLE;
                        end
                        else
                        begin
                            add(op_kind(), tok_start, 8'd1, lead);
                            scan_fresh(c, at);
                        end
                    cst_pkg::MODE_STR:
                        if (c == cst_pkg::CH_QUOTE)
                        begin
                            add(cst_pkg::KIND_STR, tok_start, tok_len, lead);
                            mode = cst_pkg::MODE_IDLE;
                        end
                        else if (!grow(c))
                            halt(at, c);
                    cst_pkg::MODE_WORD:
                        if (is_letter(c))
                        begin
                            idx = int'(tok_len);
                            if (!grow(c))
                                halt(at, c);
                            else
                            begin
                                for (int i = 0; i < 4; i++)
                                begin
                                    w = reserved_word(i);
                                    if (idx >= w.len() || w[idx] != c)
                                        word_hits[i] = 1'b0;
                                end
                            end
                        end
                        else
                        begin
                            close_word();
                            scan_fresh(c, at);
                        end
                    default:
                        scan_fresh(c, at);
                endcase
            end
            if (fresh.size() > 0)
                fresh[fresh.size() - 1].last = 1'b1;
            foreach (fresh[i])
                token_q.push_back(fresh[i]);
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            $display("%0t: token %s expected %0d, got %0d", $time, field, want, got);
            errors++;
        endfunction

        function void check_token(cst_pkg::result_t got);
            cst_pkg::result_t want;
            if (token_q.size() == 0)
            begin
                $display("%0t: unexpected token, kind %0d at %0d", $time, got.kind,
                         got.start_pos);
                errors++;
                return;
            end
            want = token_q.pop_front();
            if (got.kind !== want.kind)
                report("kind", 32'(want.kind), 32'(got.kind));
            if (got.start_pos !== want.start_pos)
                report("start_pos", want.start_pos, got.start_pos);
            if (got.length !== want.length)
                report("length", 32'(want.length), 32'(got.length));
            if (got.first_char !== want.first_char)
                report("first_char", 32'(want.first_char), 32'(got.first_char));
            if (got.second_char !== want.second_char)
                report("second_char", 32'(want.second_char), 32'(got.second_char));
            if (got.last !== want.last)
                report("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    cst_in_if  chars_if ();
    cst_out_if tokens_if ();

    c_subset_token_scanner #(
        .MAX_TOKEN(TOKEN_LIMIT)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars_if),
        .tokens(tokens_if)
    );

    token_scoreboard sb = new();

    int item_count  = 0;
    int idle_cycles = 0;
    int hold_left   = 0;
    bit src_calm    = 1'b0;
    bit sink_calm   = 1'b0;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic int stall_len();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(4, 40);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (src_calm || r < 60)
            return 0;
        return (r < 92) ? $urandom_range(1, 3) : $urandom_range(4, 30);
    endfunction

    function automatic int token_size(int lo, int hi);
        return ($urandom_range(0, 79) == 0) ? TOKEN_LIMIT : $urandom_range(lo, hi);
    endfunction

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'(32'h61 + r) : 8'(32'h41 + r - 26);
    endfunction

    function automatic logic [7:0] string_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == cst_pkg::CH_QUOTE);
        return b;
    endfunction

    // hold the request until the scanner takes it
    task automatic send_item(input logic [7:0] c, input logic eoi);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            chars_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        chars_if.valid        <= 1'b1;
        chars_if.ch           <= c;
        chars_if.end_of_input <= eoi;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        item_count++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic send_end();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_token(input token_class_t cls);
        int    n;
        int    flip;
        string w;
        case (cls)
            TK_INT:
            begin
                n = token_size(1, 6);
                repeat (n) send_item(8'(32'h30 + $urandom_range(0, 9)), 1'b0);
            end
            TK_WORD:
            begin
                w = token_scoreboard::reserved_word($urandom_range(0, 3));
                case ($urandom_range(0, 3))
                    0:
                    begin
                        n = token_size(1, 8);
                        repeat (n) send_item(rand_letter(), 1'b0);
                    end
                    1: send_text(w);
                    2: send_text(w.substr(0, $urandom_range(0, w.len() - 2)));
                    default:
                    begin
                        flip = $urandom_range(0, w.len());
                        for (int i = 0; i < w.len(); i++)
                            send_item((i == flip) ? (w[i] ^ 8'h20) : w[i], 1'b0);
                        if (flip == w.len())
                            send_item(rand_letter(), 1'b0);
                    end
                endcase
            end
            TK_PUNCT: send_item(PUNCT_SET[$urandom_range(0, 4)], 1'b0);
            TK_SOP:   send_item(SOP_SET[$urandom_range(0, 4)], 1'b0);
            TK_DOP:
            begin
                send_item(DOP_SET[$urandom_range(0, 5)], 1'b0);
                if ($urandom_range(0, 1))
                    send_item(DOP_SET[$urandom_range(0, 5)], 1'b0);
            end
            default:
            begin
                n = token_size(0, 8);
                send_item(cst_pkg::CH_QUOTE, 1'b0);
                repeat (n) send_item(string_byte(), 1'b0);
                send_item(cst_pkg::CH_QUOTE, 1'b0);
            end
        endcase
    endtask

    task automatic send_gap_char();
        send_item($urandom_range(0, 1) ? cst_pkg::CH_SPACE : cst_pkg::CH_NL, 1'b0);
    endtask

    task automatic send_random_source();
        token_class_t cls;
        token_class_t prev;
        logic [7:0]   b;
        int           r;
        prev = TK_PUNCT;
        while (item_count < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 49) == 0)
                src_calm = ~src_calm;
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                send_end();
                prev = TK_PUNCT;
            end
            else if (r < 10)
            begin
                // stray punctuation, operators and whitespace between tokens
                do
                    b = 8'($urandom_range(0, 255));
                while (!token_scoreboard::is_known(b) || b == cst_pkg::CH_QUOTE ||
                       token_scoreboard::is_digit(b) || token_scoreboard::is_letter(b));
                send_item(b, 1'b0);
            end
            else
            begin
                cls = token_class_t'($urandom_range(0, 5));
                if ((cls == prev && (cls == TK_INT || cls == TK_WORD)) ||
                    $urandom_range(0, 1))
                    send_gap_char();
                send_token(cls);
                prev = cls;
            end
        end
        send_end();
    endtask

    task automatic send_fault();
        logic [7:0] b;
        repeat ($urandom_range(0, 3)) send_token(token_class_t'($urandom_range(0, 5)));
        send_gap_char();
        case (fault_t'($urandom_range(0, 2)))
            FLT_BAD_CHAR:
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (token_scoreboard::is_known(b));
                send_item(b, 1'b0);
            end
            FLT_TOO_LONG:
                case ($urandom_range(0, 2))
                    0: repeat (TOKEN_LIMIT + 1)
                           send_item(8'(32'h30 + $urandom_range(0, 9)), 1'b0);
                    1: repeat (TOKEN_LIMIT + 1) send_item(rand_letter(), 1'b0);
                    default:
                    begin
                        send_item(cst_pkg::CH_QUOTE, 1'b0);
                        repeat (TOKEN_LIMIT + 1) send_item(string_byte(), 1'b0);
                    end
                endcase
            default:
            begin
                send_item(cst_pkg::CH_QUOTE, 1'b0);
                repeat ($urandom_range(0, 5)) send_item(string_byte(), 1'b0);
                send_end();
            end
        endcase
        // the scanner stays halted: nothing more may come out
        repeat (4) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        send_end();
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            tokens_if.ready <= 1'b0;
            hold_left       <= 0;
        end
        else if (hold_left > 0)
        begin
            tokens_if.ready <= 1'b0;
            hold_left       <= hold_left - 1;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                sink_calm <= ~sink_calm;
            if (!sink_calm && $urandom_range(0, 99) < 25)
            begin
                tokens_if.ready <= 1'b0;
                hold_left       <= stall_len() - 1;
            end
            else
                tokens_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cst_pkg::result_t got;
        if (rst_n)
        begin
            if (chars_if.valid && chars_if.ready)
                sb.note_char(chars_if.ch, chars_if.end_of_input);
            if (tokens_if.valid && tokens_if.ready)
            begin
                got.kind        = cst_pkg::kind_t'(tokens_if.kind);
                got.start_pos   = tokens_if.start_pos;
                got.length      = tokens_if.length;
                got.first_char  = tokens_if.first_char;
                got.second_char = tokens_if.second_char;
                got.last        = tokens_if.last;
                sb.check_token(got);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (chars_if.valid && chars_if.ready) ||
            (tokens_if.valid && tokens_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        chars_if.valid        = 1'b0;
        chars_if.ch           = 8'h00;
        chars_if.end_of_input = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_text("while(a>=9){\"\"}\n");
        send_text("Int!-%void<bool=");
        send_end();

        send_random_source();
        send_fault();
        chars_if.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
